// ----- design/cae_pkg.sv -----
`timescale 1ns / 1ps

package cae_pkg;

  localparam int unsigned COLOR_W = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DUR_W   = 22;
  // widest dividend: a 22-bit remainder times the hue step count
  localparam int unsigned DIV_W   = 33;
  localparam int unsigned HUE_W   = 11;

  localparam logic [TIME_W-1:0] MIN_STEP_MS = 32'd100;
  localparam int unsigned       HUE_STEPS   = 1536;
  localparam logic [9:0]        PULSE_SPAN  = 10'd510;
  localparam logic [7:0]        LEVEL_MAX   = 8'd255;
  localparam logic [DUR_W-1:0]  DUR_RESET   = 22'd4000;

  // x / 255 == (x * 0x8081) >> 23 for every x up to 255 * 255
  localparam logic [16:0]       RECIP_255   = 17'h08081;
  localparam int unsigned       RECIP_SHIFT = 23;

  typedef enum logic [1:0] {
    MODE_FIX,
    MODE_FADE,
    MODE_PULSE,
    MODE_WHEEL
  } mode_t;

  typedef enum logic {
    OP_TICK,
    OP_COLOR
  } op_t;

  typedef enum logic {
    REG_MODE,
    REG_DURATION
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MOD_WAIT,
    ST_SCALE_WAIT,
    ST_BLEND_MUL,
    ST_BLEND_ADD,
    ST_FINISH
  } state_t;

  // what a word does once it has been looked at
  typedef enum logic [2:0] {
    PATH_NEW_COLOR,
    PATH_JUMP,
    PATH_SKIP,
    PATH_FADE_DIV,
    PATH_MOD,
    PATH_KEEP
  } path_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DUR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DUR_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- design/cae_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module cae_div (
  input  logic              clk,
  input  logic              rst,
  input  cae_pkg::div_req_t req,
  output cae_pkg::div_rsp_t rsp
);
  import cae_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DUR_W-1:0] rem;
  logic [DUR_W-1:0] dvs;
  logic [DIV_W-1:0] quo;

  logic [DUR_W:0]   trial;
  logic             fits;
  logic [DUR_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[DIV_W-1]};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? DUR_W'(trial - {1'b0, dvs}) : trial[DUR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ----- design/color_animation_engine_unit.sv -----
`timescale 1ns / 1ps

// Colour animation engine. Words in on the s_ stream are either a millisecond
// tick (tuser 0) or a new target colour stamped with the time (tuser 1); a
// colour word (0xWWRRGGBB) leaves on the m_ stream only when a tick changes
// the current colour. Register 0 (mode: fix, fade, pulse, hue wheel) also
// copies the current colour into the target when written; register 1 holds
// the duration in ms, 0 acting as 1. Words are taken one at a time, and the
// next is accepted only once the last is through. The time per word is set
// by the shared bit-serial divider (33 iterations; one division for a fade,
// two for pulse and wheel) plus a multiply and an add state per colour
// channel in the blend, and a finished step waits while the previous output
// word is unread. A finished word waits in the output register while the
// next input word is taken.
module color_animation_engine_unit (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] now_ms, [63:32] new_color
  input  logic [0:0]  s_tuser,   // [0] op
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] color
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cae_pkg::*;

  // registers
  mode_t              mode;
  logic [DUR_W-1:0]   duration;

  // animation state
  logic [COLOR_W-1:0] current_color;
  logic [COLOR_W-1:0] target_color;
  logic [COLOR_W-1:0] fade_start_color;
  logic [TIME_W-1:0]  fade_start_time;
  logic [TIME_W-1:0]  last_step_time;

  // word being worked on
  op_t                item_op;
  logic [TIME_W-1:0]  item_now;
  logic [COLOR_W-1:0] item_color;

  // working registers
  logic [COLOR_W-1:0] next_color;
  logic [COLOR_W-1:0] blend_from;
  logic [COLOR_W-1:0] blend_to;
  logic [7:0]         blend_f;
  logic [1:0]         chan;
  logic [15:0]        prod;
  logic               prod_neg;

  state_t             state;
  state_t             state_next;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // combinational helpers
  logic [DUR_W-1:0]   dur_eff;
  logic               cur_ne_tgt;
  logic               thr_ok;
  logic [TIME_W-1:0]  fade_d;
  logic               fade_done;
  path_t              path;
  logic               cfg_wr;
  logic               out_load;
  logic [9:0]         scale_q;
  logic [7:0]         level;
  logic [7:0]         ch_a;
  logic [7:0]         ch_b;
  logic [7:0]         ch_mag;
  logic               ch_neg;
  logic [32:0]        recip_prod;
  logic [7:0]         ch_q;
  logic [7:0]         ch_c;

  function automatic logic [COLOR_W-1:0] hue_to_rgb(input logic [HUE_W-1:0] hue);
    logic [7:0] off;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    off = hue[7:0];
    r   = '0;
    g   = '0;
    b   = '0;
    unique case (hue[HUE_W-1:8])
      3'd0: begin
        r = LEVEL_MAX;
        g = off;
      end
      3'd1: begin
        r = LEVEL_MAX - off;
        g = LEVEL_MAX;
      end
      3'd2: begin
        g = LEVEL_MAX;
        b = off;
      end
      3'd3: begin
        g = LEVEL_MAX - off;
        b = LEVEL_MAX;
      end
      3'd4: begin
        r = off;
        b = LEVEL_MAX;
      end
      default: begin
        r = LEVEL_MAX;
        b = LEVEL_MAX - off;
      end
    endcase
    return {8'h00, r, g, b};
  endfunction

  cae_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // decisions on the held word
  always_comb begin
    dur_eff    = (duration == '0) ? DUR_W'(1) : duration;
    cur_ne_tgt = current_color != target_color;
    thr_ok     = (item_now - last_step_time) >= MIN_STEP_MS;
    fade_d     = item_now - fade_start_time;
    fade_done  = fade_d >= TIME_W'(dur_eff);
    priority if (item_op == OP_COLOR) begin
      path = PATH_NEW_COLOR;
    end else if (mode == MODE_FIX && cur_ne_tgt) begin
      path = PATH_JUMP;
    end else if (!thr_ok) begin
      path = PATH_SKIP;
    end else if (mode == MODE_FADE && cur_ne_tgt) begin
      path = fade_done ? PATH_JUMP : PATH_FADE_DIV;
    end else if (mode == MODE_PULSE || mode == MODE_WHEEL) begin
      path = PATH_MOD;
    end else begin
      path = PATH_KEEP;
    end
  end

  // scale result: hue, fade factor or folded pulse level
  always_comb begin
    scale_q = div_rsp.quotient[9:0];
    if (mode == MODE_PULSE && scale_q > 10'(LEVEL_MAX)) begin
      level = 8'(PULSE_SPAN - scale_q);
    end else begin
      level = scale_q[7:0];
    end
  end

  // one channel of the blend; q = |b - a| * f / 255 via reciprocal
  always_comb begin
    ch_a       = blend_from[{chan, 3'b000} +: 8];
    ch_b       = blend_to[{chan, 3'b000} +: 8];
    ch_neg     = ch_b < ch_a;
    ch_mag     = ch_neg ? ch_a - ch_b : ch_b - ch_a;
    recip_prod = 33'(prod) * 33'(RECIP_255);
    ch_q       = recip_prod[RECIP_SHIFT +: 8];
    ch_c       = prod_neg ? ch_a - ch_q : ch_a + ch_q;
  end

  assign out_load = (state == ST_FINISH) && (next_color != current_color)
                    && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (path)
          PATH_NEW_COLOR, PATH_SKIP: state_next = ST_IDLE;
          PATH_JUMP, PATH_KEEP:      state_next = ST_FINISH;
          PATH_FADE_DIV:             state_next = ST_SCALE_WAIT;
          default:                   state_next = ST_MOD_WAIT;
        endcase
      end
      ST_MOD_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_SCALE_WAIT;
        end
      end
      ST_SCALE_WAIT: begin
        if (div_rsp.done) begin
          state_next = (mode == MODE_WHEEL) ? ST_FINISH : ST_BLEND_MUL;
        end
      end
      ST_BLEND_MUL: begin
        state_next = ST_BLEND_ADD;
      end
      ST_BLEND_ADD: begin
        state_next = (chan == 2'd3) ? ST_FINISH : ST_BLEND_MUL;
      end
      default: begin
        // finish: hold while a changed colour waits on an unread previous word
        if (next_color == current_color || !m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // handshakes and divider requests
  always_comb begin
    s_tready         = state == ST_IDLE;
    pready           = 1'b1;
    cfg_wr           = psel && penable && pwrite;
    prdata           = (reg_idx_t'(paddr[2]) == REG_MODE) ? {30'd0, mode}
                                                          : {10'd0, duration};
    div_req.divisor  = dur_eff;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(item_now);
    if (state == ST_DISPATCH && path == PATH_FADE_DIV) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(fade_d[DUR_W-1:0]) * DIV_W'(LEVEL_MAX);
    end else if (state == ST_DISPATCH && path == PATH_MOD) begin
      div_req.start    = 1'b1;
    end else if (state == ST_MOD_WAIT && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(div_rsp.remainder)
                         * ((mode == MODE_WHEEL) ? DIV_W'(HUE_STEPS) : DIV_W'(PULSE_SPAN));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chan  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_BLEND_ADD) begin
        chan <= chan + 1'b1;
      end
    end
  end

  // registers and animation state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_FIX;
      duration         <= DUR_RESET;
      current_color    <= '0;
      target_color     <= '0;
      fade_start_color <= '0;
      fade_start_time  <= '0;
      last_step_time   <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[2]))
          REG_MODE: begin
            mode         <= mode_t'(pwdata[1:0]);
            target_color <= current_color;
          end
          default: begin
            duration <= pwdata[DUR_W-1:0];
          end
        endcase
      end
      if (state == ST_DISPATCH && path == PATH_NEW_COLOR) begin
        if (mode == MODE_FADE) begin
          fade_start_color <= current_color;
          target_color     <= item_color;
          fade_start_time  <= item_now;
        end else if (mode != MODE_WHEEL) begin
          target_color <= item_color;
        end
      end
      if (state == ST_FINISH) begin
        last_step_time <= item_now;
      end
      if (out_load) begin
        current_color <= next_color;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_op    <= op_t'(s_tuser[0]);
      item_now   <= s_tdata[31:0];
      item_color <= s_tdata[63:32];
    end
    if (state == ST_DISPATCH) begin
      blend_to   <= target_color;
      blend_from <= (path == PATH_FADE_DIV) ? fade_start_color : '0;
      next_color <= (path == PATH_JUMP) ? target_color : current_color;
    end
    if (state == ST_SCALE_WAIT && div_rsp.done) begin
      if (mode == MODE_WHEEL) begin
        next_color <= hue_to_rgb(div_rsp.quotient[HUE_W-1:0]);
      end else begin
        blend_f <= level;
      end
    end
    if (state == ST_BLEND_MUL) begin
      prod     <= 16'(ch_mag) * 16'(blend_f);
      prod_neg <= ch_neg;
    end
    if (state == ST_BLEND_ADD) begin
      next_color[{chan, 3'b000} +: 8] <= ch_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= next_color;
    end
  end

  // a division result only lands while the sequencer waits for it
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_MOD_WAIT || state == ST_SCALE_WAIT))
    else $error("divider result with no waiting step");

  // channel count only moves inside the blend
  a_chan_in_blend: assert property (@(posedge clk) disable iff (rst)
    (chan != 2'd0) |-> (state == ST_BLEND_MUL || state == ST_BLEND_ADD))
    else $error("blend channel count left nonzero");

  // a fresh output word is the colour just committed
  a_out_matches_current: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (m_tdata == current_color))
    else $error("output word differs from current colour");

  // a fix-mode tick always lands on the target
  a_fix_reaches_target: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && mode == MODE_FIX) |-> (next_color == target_color))
    else $error("fix mode tick missed the target");

endmodule

// ----- tb/tb_color_animation_engine_unit.sv -----
`timescale 1ns / 1ps

// Checks the colour animation engine: a local model of the four modes runs
// beside the block, works out the colour word that each accepted input word
// should give, and the result stream is compared word by word in order.
module tb_color_animation_engine_unit;
  import cae_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 1000000;
  localparam int unsigned SETTLE_CYCLES = 120;   // outlasts the longest step
  localparam int unsigned HOLD_LEN      = 400;   // long sink stall

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;   // [31:0] now_ms, [63:32] new_color
  logic [0:0]  s_tuser  = '0;   // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [31:0] color
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  color_animation_engine_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Local model of the engine: registers and animation state
  // ---------------------------------------------------------------------
  mode_t            mode_r    = MODE_FIX;
  logic [DUR_W-1:0] dur_r     = DUR_RESET;
  logic [31:0]      cur_col   = '0;
  logic [31:0]      tgt_col   = '0;
  logic [31:0]      fade_from = '0;
  logic [31:0]      fade_t0   = '0;
  logic [31:0]      step_t    = '0;

  logic [31:0] expected_colours[$];
  int unsigned errors      = 0;
  int unsigned idle_max    = 6;   // 0 gives stretches with no idling
  logic [31:0] wall_ms     = '0;  // stimulus clock in ms
  int unsigned cycle_count = 0;

  // sink hold-off requests: a test bumps hold_asks, the sink process serves it
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned rx_gap    = 0;

  // per-channel linear blend, signed divide truncating toward zero
  function automatic logic [31:0] mix_colour(logic [31:0] from, logic [31:0] to, int f);
    logic [31:0] res;
    int a, b, c;
    if (f <= 0) return from;
    if (f >= 255) return to;
    res = '0;
    for (int sh = 24; sh >= 0; sh -= 8) begin
      a = int'((from >> sh) & 32'hFF);
      b = int'((to >> sh) & 32'hFF);
      c = a + ((b - a) * f) / 255;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      res |= 32'(c) << sh;
    end
    return res;
  endfunction

  // six 256-step segments round the hue circle, white byte zero
  function automatic logic [31:0] hue_rgb(int unsigned hue);
    logic [7:0] off, r, g, b;
    off = 8'(hue % 256);
    r = '0;
    g = '0;
    b = '0;
    if (hue < 256) begin
      r = 8'hFF; g = off;
    end else if (hue < 512) begin
      r = 8'hFF - off; g = 8'hFF;
    end else if (hue < 768) begin
      g = 8'hFF; b = off;
    end else if (hue < 1024) begin
      g = 8'hFF - off; b = 8'hFF;
    end else if (hue < 1280) begin
      r = off; b = 8'hFF;
    end else begin
      r = 8'hFF; b = 8'hFF - off;
    end
    return {8'h00, r, g, b};
  endfunction

  // advances the model by one input word; returns 1 when a colour word is due
  function automatic bit step_colour(op_t op, logic [31:0] now, logic [31:0] nc,
                                     output logic [31:0] col);
    longint unsigned dur, elapsed, q;
    logic [31:0] next, since;
    dur   = (dur_r == '0) ? 64'd1 : 64'(dur_r);
    next  = cur_col;
    since = now - step_t;
    col   = '0;
    if (op == OP_COLOR) begin
      if (mode_r == MODE_FADE) begin
        fade_from = cur_col;
        tgt_col   = nc;
        fade_t0   = now;
      end else if (mode_r != MODE_WHEEL) begin
        tgt_col = nc;
      end
      return 1'b0;
    end
    if (mode_r == MODE_FIX && cur_col != tgt_col) begin
      next = tgt_col;               // fix jump ignores the step throttle
    end else if (since < MIN_STEP_MS) begin
      return 1'b0;
    end else if (mode_r == MODE_FADE && cur_col != tgt_col) begin
      elapsed = 64'(32'(now - fade_t0));
      if (elapsed >= dur) next = tgt_col;
      else next = mix_colour(fade_from, tgt_col, int'(elapsed * 255 / dur));
    end else if (mode_r == MODE_PULSE) begin
      q = (64'(now) % dur) * 510 / dur;
      if (q > 255) q = 510 - q;     // ramp back down in the second half
      next = mix_colour('0, tgt_col, int'(q));
    end else if (mode_r == MODE_WHEEL) begin
      q = (64'(now) % dur) * HUE_STEPS / dur;
      next = hue_rgb(int'(q));
    end
    step_t = now;
    if (next != cur_col) begin
      cur_col = next;
      col     = next;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // one word on the input stream; valid stays up when no gap is drawn
  task automatic send_word(op_t op, logic [31:0] now, logic [31:0] nc);
    int unsigned gap;
    logic [31:0] col;
    gap = $urandom_range(0, idle_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {nc, now};
    do @(posedge clk); while (!s_tready);
    if (step_colour(op, now, nc, col)) expected_colours.push_back(col);
  endtask

  // setup then access phase; model register follows at the write edge
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_MODE) begin
      mode_r  = mode_t'(val[1:0]);
      tgt_col = cur_col;
    end else begin
      dur_r = val[DUR_W-1:0];
    end
    @(posedge clk);
  endtask

  // stop sending, let every expected word come out, then let the last
  // (possibly silent) step finish before touching the registers
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_colour();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly past the step throttle, some inside it, the odd wild jump
  function automatic logic [31:0] advance_time();
    int unsigned r;
    r = $urandom_range(0, 31);
    if (r == 0) wall_ms = $urandom;
    else if (r < 4) wall_ms += $urandom_range(0, 99);
    else wall_ms += $urandom_range(100, 260);
    return wall_ms;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // reset state is fix mode: jump straight to each new target
  task automatic test_fix_jump();
    send_word(OP_TICK,  32'd5,  $urandom);        // inside throttle, nothing
    send_word(OP_COLOR, 32'd10, 32'hFFFF_FFFF);
    send_word(OP_TICK,  32'd12, $urandom);        // jump despite throttle
    send_word(OP_COLOR, 32'd20, 32'h0000_0000);
    send_word(OP_TICK,  32'd25, $urandom);
    send_word(OP_COLOR, 32'd30, 32'h80A5_5A01);
    send_word(OP_TICK,  32'd40, $urandom);
    send_word(OP_TICK,  32'd400, $urandom);       // already at target
  endtask

  // channels moving both up and down, mid-fade and past the end
  task automatic test_fade();
    wait_drained();
    reg_write(REG_DURATION, 32'd1000);
    reg_write(REG_MODE, 32'(MODE_FADE));
    send_word(OP_COLOR, 32'd1000, 32'h1FFF_00C8);
    send_word(OP_TICK,  32'd1050, $urandom);
    send_word(OP_TICK,  32'd1790, $urandom);
    send_word(OP_TICK,  32'd2050, $urandom);      // elapsed past duration
  endtask

  // rising half, folded half, throttled tick
  task automatic test_pulse();
    wait_drained();
    reg_write(REG_MODE, 32'(MODE_PULSE));
    send_word(OP_COLOR, 32'd3000, 32'hFFFF_FFFF);
    send_word(OP_TICK,  32'd3250, $urandom);
    send_word(OP_TICK,  32'd3700, $urandom);
    send_word(OP_TICK,  32'd4500, $urandom);      // peak brightness
    send_word(OP_TICK,  32'd4550, $urandom);
  endtask

  // one tick in each hue segment, then zero duration acting as one
  task automatic test_wheel();
    wait_drained();
    reg_write(REG_DURATION, 32'd1536);
    reg_write(REG_MODE, 32'(MODE_WHEEL));
    send_word(OP_COLOR, 32'd6200, 32'h1234_5678); // ignored in wheel mode
    send_word(OP_TICK,  32'd6244, $urandom);
    send_word(OP_TICK,  32'd6444, $urandom);
    send_word(OP_TICK,  32'd6744, $urandom);
    send_word(OP_TICK,  32'd6944, $urandom);
    send_word(OP_TICK,  32'd7244, $urandom);
    send_word(OP_TICK,  32'd7544, $urandom);
    wait_drained();
    reg_write(REG_DURATION, 32'd0);
    send_word(OP_TICK,  32'd7700, $urandom);
  endtask

  // fade straddling the 32-bit ms wrap
  task automatic test_time_wrap();
    wait_drained();
    reg_write(REG_DURATION, 32'd300);
    reg_write(REG_MODE, 32'(MODE_FADE));
    send_word(OP_COLOR, 32'hFFFF_FF00, 32'h00C0_FF33);
    send_word(OP_TICK,  32'hFFFF_FF80, $urandom);
    send_word(OP_TICK,  32'h0000_0010, $urandom);
    send_word(OP_TICK,  32'h0000_0030, $urandom); // throttled just after the wrap
    send_word(OP_TICK,  32'h0000_00A0, $urandom);
    wall_ms = 32'h0000_0200;
  endtask

  // sink holds off for a long stretch while fix jumps keep coming, so the
  // output register and the engine both fill and s_tready drops
  task automatic test_backpressure();
    wait_drained();
    reg_write(REG_DURATION, 32'd4000);
    reg_write(REG_MODE, 32'(MODE_FIX));
    idle_max = 0;
    hold_asks++;
    repeat (30) begin
      wall_ms += 32'd7;
      send_word(OP_COLOR, wall_ms, pick_colour());
      send_word(OP_TICK, wall_ms, $urandom);
    end
    // sender pauses until every colour word is out
    wait_drained();
    idle_max = 6;
  endtask

  // one register setting, then well-formed traffic with some noise
  task automatic test_random_phase(mode_t m, logic [DUR_W-1:0] dur,
                                   int unsigned n_words, int unsigned gaps);
    int unsigned pick;
    wait_drained();
    idle_max = gaps;
    // junk in the unused upper bits of both registers
    reg_write(REG_DURATION, {10'($urandom), dur});
    reg_write(REG_MODE, {30'($urandom), m});
    repeat (n_words) begin
      pick = $urandom_range(0, 15);
      if (pick < 3 || (m == MODE_FIX && pick < 7))
        send_word(OP_COLOR, wall_ms, pick_colour());
      else
        send_word(OP_TICK, advance_time(), $urandom);
    end
  endtask

  // ---------------------------------------------------------------------
  // Sink: random ready per word, plus long hold-offs on request
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    int unsigned gap_draw;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   <= 0;
    end else if (hold_asks != hold_done) begin
      hold_done <= hold_asks;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= (hold_left == 1);
    end else if (m_tready && m_tvalid) begin
      gap_draw = $urandom_range(0, idle_max);
      rx_gap   <= gap_draw;
      m_tready <= (gap_draw == 0);
    end else if (rx_gap != 0) begin
      rx_gap   <= rx_gap - 1;
      m_tready <= (rx_gap == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Result check: every colour word against the oldest expected one
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_colours.size() == 0) begin
        $display("%0t: unexpected colour word, expected none, got %08h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_colours.pop_front();
        if (m_tdata !== want) begin
          $display("%0t: colour word wrong, expected %08h, got %08h", $time, want, m_tdata);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("color_animation_engine_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_fix_jump();
    test_fade();
    test_pulse();
    test_wheel();
    test_time_wrap();
    test_backpressure();
    test_random_phase(MODE_FADE,  22'd1000,    132, 6);
    test_random_phase(MODE_PULSE, 22'd700,     132, 6);
    test_random_phase(MODE_WHEEL, 22'h3FFFFF,  132, 6);
    test_random_phase(MODE_FIX,   22'd3600000, 132, 0);
    test_random_phase(MODE_FADE,  22'd0,       132, 6);
    test_random_phase(MODE_PULSE, 22'd2500,    132, 6);
    test_random_phase(MODE_WHEEL, 22'd1536,    132, 0);
    test_random_phase(MODE_FADE,  22'd4000,    132, 6);
    wait_drained();
    if (errors == 0) begin
      $display("color_animation_engine_unit: match");
    end else begin
      $display("color_animation_engine_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/cae_pkg.sv
design/cae_div.sv
design/color_animation_engine_unit.sv
tb/tb_color_animation_engine_unit.sv
